[sv/kct_pkg.sv]
// Package for the keyed counter table: sizes, opcode and status codes,
// and the memory write and search result bundles.
// No dependencies.
package kct_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int KEY_W         = 32;
  localparam int CNT_DATA_W    = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SET = 2'd1,
    OP_GET = 2'd2
  } kct_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } kct_status_e;

  // One write into a table memory
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [31:0]      data;
  } kct_wr_t;

  // Outcome of a key search, valid for the cycle in which done is high
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] slot;
  } kct_srch_t;

endpackage

[sv/keyed_counter_table.sv]
// Keyed counter table: 32-bit counters looked up by 32-bit key.
// On a miss the search scans every slot below the fill count; on a hit it stops
// at the matching slot (linear key search, one key memory read per cycle).
// Throughput: one item at a time; the next item is taken once the result
// is loaded into the output register. Opcode three skips the search and returns OK, zero.
// Reset clears the fill count and control state; memories are not cleared.
module keyed_counter_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] value_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] value_out_o
);
  import kct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_UPDATE = 4'b0100,
    S_EMIT   = 4'b1000
  } kct_state_e;

  kct_state_e       state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [1:0]       op_q;
  logic [31:0]      key_q;
  logic [31:0]      val_q;
  logic             hit_q;
  logic [IDX_W-1:0] slot_q;
  logic [1:0]       res_status_q, res_status_d;
  logic [31:0]      res_value_q, res_value_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q;
  logic [31:0]      out_value_q;

  logic             accept;
  logic             start;
  logic             out_load;
  kct_srch_t        srch;
  kct_wr_t          key_wr;
  kct_wr_t          cnt_wr;
  logic [31:0]      cnt_rd_data;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign start      = accept && (opcode_i != OP_ADD) && (opcode_i != OP_SET)
                      ? (opcode_i == OP_GET) : accept;
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  kct_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .key_i  (key_i),
    .fill_i (fill_q),
    .wr_i   (key_wr),
    .srch_o (srch)
  );

  kct_count_mem u_count (
    .clk_i    (clk_i),
    .rd_en_i  (srch.done),
    .rd_addr_i(srch.slot),
    .rd_data_o(cnt_rd_data),
    .wr_i     (cnt_wr)
  );

  // Sequence one item: search, read-modify-write, emit (opcode three goes straight to emit)
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    key_wr       = '{en: 1'b0, addr: fill_q[IDX_W-1:0], data: key_q};
    cnt_wr       = '{en: 1'b0, addr: slot_q, data: val_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_OK;
          res_value_d  = '0;
          state_d      = start ? S_SEARCH : S_EMIT;
        end
      end
      S_SEARCH: begin
        if (srch.done) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_d = S_EMIT;
        if (hit_q) begin
          unique case (kct_op_e'(op_q))
            OP_ADD: begin
              cnt_wr.en   = 1'b1;
              cnt_wr.data = cnt_rd_data + val_q;
            end
            OP_SET: begin
              cnt_wr.en = 1'b1;
            end
            OP_GET: begin
              res_value_d = cnt_rd_data;
            end
            default: begin
            end
          endcase
        end else if (fill_q >= CNT_W'(TABLE_ENTRIES)) begin
          res_status_d = ST_FULL;
        end else if (op_q == OP_GET) begin
          res_status_d = ST_NOT_FOUND;
        end else begin
          // Insert the key in the next free slot
          key_wr.en   = 1'b1;
          cnt_wr.en   = 1'b1;
          cnt_wr.addr = fill_q[IDX_W-1:0];
          fill_d      = fill_q + CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the output item until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item, the search outcome and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      val_q <= value_in_i;
    end
    if (srch.done) begin
      hit_q  <= srch.hit;
      slot_q <= srch.slot;
    end
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_out_o = out_value_q;

endmodule

[sv/kct_search.sv]
// Key memory of the keyed counter table with a linear search engine.
// Scans slots below the fill count, one read per cycle. Depends on kct_pkg.
module kct_search (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [31:0]               key_i,
  input  logic [kct_pkg::CNT_W-1:0] fill_i,
  input  kct_pkg::kct_wr_t          wr_i,
  output kct_pkg::kct_srch_t        srch_o
);
  import kct_pkg::*;

  logic [KEY_W-1:0] mem [TABLE_ENTRIES];
  logic [KEY_W-1:0] rd_data_q;
  logic [KEY_W-1:0] key_q;
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             cmp_valid_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             hit_now;
  logic             finish;
  logic             issue;

  // Compare the slot read last cycle; stop on a match or once the scan reaches the fill count
  assign hit_now = cmp_valid_q && (rd_data_q == key_q);
  assign finish  = busy_q && (hit_now || (scan_q >= fill_i));
  assign issue   = busy_q && !finish;

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (issue) begin
      rd_data_q <= mem[scan_q[IDX_W-1:0]];
    end
  end

  // Advance the scan pointer
  always_comb begin
    busy_d = busy_q;
    scan_d = scan_q;
    if (start_i) begin
      busy_d = 1'b1;
      scan_d = '0;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (issue) begin
      scan_d = scan_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      scan_q      <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      scan_q      <= scan_d;
      cmp_valid_q <= issue;
    end
  end

  // Hold the search key and the slot under compare
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (issue) begin
      cmp_idx_q <= scan_q[IDX_W-1:0];
    end
  end

  assign srch_o.done = finish;
  assign srch_o.hit  = hit_now;
  assign srch_o.slot = cmp_idx_q;

endmodule

[sv/kct_count_mem.sv]
// Counter memory of the keyed counter table: one write port and one
// read port with registered read data. Depends on kct_pkg.
module kct_count_mem (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [kct_pkg::IDX_W-1:0] rd_addr_i,
  output logic [31:0]               rd_data_o,
  input  kct_pkg::kct_wr_t          wr_i
);
  import kct_pkg::*;

  logic [CNT_DATA_W-1:0] mem [TABLE_ENTRIES];
  logic [CNT_DATA_W-1:0] rd_data_q;

  // Write back and read one counter per cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/kct_checker.sv]
// Port-level checks for the keyed counter table, bound to the top level.
// Depends on kct_pkg for the status codes.
module kct_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         opcode_i,
  input logic signed [31:0] key_i,
  input logic signed [31:0] value_in_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic signed [31:0] value_out_o
);
  import kct_pkg::*;

  // A waiting input item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(opcode_i) && $stable(key_i) && $stable(value_in_i))
    else $error("waiting input item changed");

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(value_out_o))
    else $error("stalled result changed");

  // The block works on one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

  // Only defined status codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_NOT_FOUND) || (status_o == ST_FULL))
    else $error("undefined status code");

  // A miss or a full table returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> value_out_o == 32'sd0)
    else $error("nonzero value with error status");

endmodule

bind keyed_counter_table kct_checker u_kct_checker (.*);
